>>> src/jsd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and log table builder for the jsd loss block
// no dependencies

package jsd_pkg;

    localparam int P_W     = 31;
    localparam int X_W     = 33;
    localparam int A_W     = 32;
    localparam int LN_W    = 36;
    localparam int MAG_W   = 35;
    localparam int TERM_W  = 40;
    localparam int OUT_W   = 52;
    localparam int BC_W    = 16;
    localparam int FRAC_W  = 30;

    localparam logic [FRAC_W-1:0] LN2_Q30 = 30'd744261118;
    localparam logic signed [LN_W-1:0] LN2_S = LN_W'(LN2_Q30);

    localparam logic [P_W-1:0]  THRESH_RESET = 31'd10737;
    localparam logic [BC_W-1:0] BATCH_RESET  = 16'd1;

    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_BATCH  = 1'b1;

    typedef struct packed {
        logic [TERM_W-1:0] term;
        logic              last;
    } t_qent;

    // q30 ln of 1 + idx/2^lbits, built by repeated squaring of the mantissa
    function automatic logic [FRAC_W-1:0] ln_entry(input int unsigned idx,
                                                   input int unsigned lbits);
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] t;
        m = (64'd1 << FRAC_W) + (64'(idx) << (FRAC_W - lbits));
        r = '0;
        for (int b = FRAC_W - 1; b >= 0; b--) begin
            m = (m * m) >> FRAC_W;
            if (m >= (64'd2 << FRAC_W)) begin
                m    = m >> 1;
                r[b] = 1'b1;
            end
        end
        t = (r * 64'(LN2_Q30)) >> FRAC_W;
        return t[FRAC_W-1:0];
    endfunction

endpackage

>>> src/jsd_front.sv
`timescale 1ns / 1ps
// front end: accepts element pairs, classifies them and computes one term
// with a shared log lookup and split multiplier; uses jsd_pkg

module jsd_front import jsd_pkg::*; #(
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [P_W-1:0] i_p,
    input  logic [P_W-1:0] i_q,
    input  logic           i_last,
    input  logic [P_W-1:0] i_threshold,
    input  logic           i_q_full,
    output logic           o_push,
    output t_qent          o_push_data
);

    localparam int TAB_N = 1 << LOG_TABLE_BITS;
    localparam int PROD_W = A_W + MAG_W;
    localparam int HI_W = MAG_W - 18;

    typedef enum logic [2:0] {
        F_IDLE, F_CLASS, F_LZ, F_TAB, F_MLO, F_MHI, F_ACC, F_PUSH
    } t_fstate;

    t_fstate r_state;
    logic [P_W-1:0] r_p, r_q;
    logic r_last;
    logic [1:0] r_k, r_nops;
    logic [A_W-1:0] r_a;
    logic [5:0] r_e;
    logic [LOG_TABLE_BITS-1:0] r_idx;
    logic [FRAC_W-1:0] r_rom;
    logic signed [LN_W-1:0] r_ln;
    logic [A_W+17:0] r_plo;
    logic [A_W+HI_W-1:0] r_phi;
    logic r_neg;
    logic signed [TERM_W-1:0] r_term;

    logic [FRAC_W-1:0] w_rom [TAB_N];

    genvar gi;
    generate
        for (gi = 0; gi < TAB_N; gi++) begin : g_rom
            localparam logic [FRAC_W-1:0] V = ln_entry(gi, LOG_TABLE_BITS);
            assign w_rom[gi] = V;
        end
    endgenerate

    // operand select for the three log products
    logic [X_W-1:0] w_x, w_xe, w_norm;
    logic [A_W-1:0] w_a;
    logic [X_W-1:0] w_sum_pq;
    logic [5:0] w_e;

    always_comb begin
        w_sum_pq = X_W'(r_p) + X_W'(r_q);
        case (r_k)
            2'd0:    begin w_x = {1'b0, r_p, 1'b0}; w_a = A_W'(r_p); end
            2'd1:    begin w_x = {1'b0, r_q, 1'b0}; w_a = A_W'(r_q); end
            default: begin w_x = w_sum_pq; w_a = w_sum_pq[A_W-1:0]; end
        endcase
        w_xe = (w_x == '0) ? X_W'(1) : w_x;
        w_e = '0;
        for (int i = 0; i < X_W; i++) begin
            if (w_xe[i]) w_e = 6'(i);
        end
        w_norm = w_xe << (6'(X_W - 1) - w_e);
    end

    logic signed [6:0] w_es;
    logic signed [LN_W-1:0] w_ln;
    logic [MAG_W-1:0] w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-FRAC_W-1:0] w_part;

    always_comb begin
        w_es = $signed({1'b0, r_e}) - 7'sd30;
        w_ln = LN_W'(w_es) * LN2_S + $signed(LN_W'(r_rom));
        w_mag = r_ln[LN_W-1] ? MAG_W'(-r_ln) : MAG_W'(r_ln);
        w_prod = PROD_W'(r_plo) + (PROD_W'(r_phi) << 18);
        // negative logs round the magnitude up, giving floor of the product
        if (r_neg)
            w_part = (PROD_W-FRAC_W)'((w_prod + PROD_W'((64'd1 << FRAC_W) - 1)) >> FRAC_W);
        else
            w_part = (PROD_W-FRAC_W)'(w_prod >> FRAC_W);
    end

    logic w_sub;
    assign w_sub = r_neg ^ (r_k == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_k     <= '0;
            r_nops  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_p     <= i_p;
                        r_q     <= i_q;
                        r_last  <= i_last;
                        r_state <= F_CLASS;
                    end
                end
                F_CLASS: begin
                    r_term <= '0;
                    r_k    <= '0;
                    if (r_p <= i_threshold) begin
                        r_a     <= A_W'(r_q);
                        r_ln    <= LN2_S;
                        r_nops  <= 2'd1;
                        r_state <= F_MLO;
                    end else if (r_q <= i_threshold) begin
                        r_a     <= A_W'(r_p);
                        r_ln    <= LN2_S;
                        r_nops  <= 2'd1;
                        r_state <= F_MLO;
                    end else begin
                        r_nops  <= 2'd3;
                        r_state <= F_LZ;
                    end
                end
                F_LZ: begin
                    r_a     <= w_a;
                    r_e     <= w_e;
                    r_idx   <= w_norm[X_W-2 -: LOG_TABLE_BITS];
                    r_state <= F_TAB;
                end
                F_TAB: begin
                    r_rom   <= w_rom[r_idx];
                    r_state <= F_MHI;
                end
                F_MHI: begin
                    r_ln    <= w_ln;
                    r_state <= F_MLO;
                end
                F_MLO: begin
                    r_neg   <= r_ln[LN_W-1];
                    r_plo   <= r_a * w_mag[17:0];
                    r_phi   <= r_a * w_mag[MAG_W-1:18];
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    if (w_sub) r_term <= r_term - TERM_W'(w_part);
                    else       r_term <= r_term + TERM_W'(w_part);
                    if (r_k + 2'd1 == r_nops) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= F_LZ;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_q_full;
    assign o_push_data.term = (r_term > 0) ? r_term : '0;
    assign o_push_data.last = r_last;

endmodule

>>> src/jsd_fifo.sv
`timescale 1ns / 1ps
// two-entry queue between the term front end and the accumulator
// uses jsd_pkg for the entry type

module jsd_fifo import jsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    input  logic  i_pop,
    output t_qent o_data,
    output logic  o_full,
    output logic  o_empty
);

    t_qent r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

>>> src/jsd_back.sv
`timescale 1ns / 1ps
// back end: accumulates terms with saturation and divides the sum by
// twice the batch count one quotient bit a cycle; uses jsd_pkg

module jsd_back import jsd_pkg::*; #(
    parameter int COUNT_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qent            i_q_data,
    input  logic             i_q_empty,
    output logic             o_pop,
    input  logic [BC_W-1:0]  i_batch,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_loss,
    output logic             o_sat
);

    localparam int SUM_W = 32 + COUNT_BITS;
    localparam int QW = SUM_W - 1;
    localparam int CW = (QW > OUT_W) ? QW : OUT_W;
    localparam int CNT_W = $clog2(QW + 1);

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} t_bstate;

    t_bstate r_state;
    logic [SUM_W-1:0] r_sum;
    logic [QW-1:0] r_quo;
    logic [BC_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic r_sat;
    logic r_valid;
    logic [OUT_W-1:0] r_loss;
    logic r_osat;

    logic [SUM_W:0] w_add;
    logic [SUM_W-1:0] w_new;
    logic [BC_W-1:0] w_bc;
    logic [BC_W:0] w_sh;
    logic w_ge;
    logic w_big;
    logic w_out_free;

    always_comb begin
        w_add = (SUM_W+1)'(r_sum) + (SUM_W+1)'(i_q_data.term);
        w_new = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];
        w_bc  = (i_batch == '0) ? BC_W'(1) : i_batch;
        w_sh  = {r_rem, r_quo[QW-1]};
        w_ge  = (w_sh >= (BC_W+1)'(w_bc));
        w_big = CW'(r_quo) > CW'({OUT_W{1'b1}});
        w_out_free = !r_valid || !i_stall;
    end

    assign o_pop = (r_state == B_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && r_state != B_DONE) r_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_q_data.last) begin
                            // sum / (2*bc) taken as (sum >> 1) / bc
                            r_quo   <= w_new[SUM_W-1:1];
                            r_sat   <= (w_new == '1);
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_state <= B_DIV;
                        end else begin
                            r_sum <= w_new;
                        end
                    end
                end
                B_DIV: begin
                    r_rem <= w_ge ? BC_W'(w_sh - (BC_W+1)'(w_bc)) : w_sh[BC_W-1:0];
                    r_quo <= {r_quo[QW-2:0], w_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QW - 1)) r_state <= B_DONE;
                end
                B_DONE: begin
                    if (w_out_free) begin
                        r_valid <= 1'b1;
                        if (r_sat || w_big) begin
                            r_loss <= '1;
                            r_osat <= 1'b1;
                        end else begin
                            r_loss <= OUT_W'(r_quo);
                            r_osat <= 1'b0;
                        end
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_loss  = r_loss;
    assign o_sat   = r_osat;

endmodule

>>> src/jsd_loss_accumulate_core.sv
`timescale 1ns / 1ps
// jsd loss accumulator: term front end, two-entry queue, accumulate/divide back end
// uses jsd_pkg, jsd_front, jsd_fifo, jsd_back
// an element pair needs one ln2 product when one side is at or below threshold,
// else three log lookups and products through one shared multiplier
// a last element adds a division of the sum by twice the batch count, one bit a cycle
// synchronous active-low reset clears the sum, queue and control; config regs reset

module jsd_loss_accumulate_core import jsd_pkg::*; #(
    parameter int COUNT_BITS = 20,
    parameter int LOG_TABLE_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [P_W-1:0]   i_predicted_prob,
    input  logic [P_W-1:0]   i_target_prob,
    input  logic             i_last_element,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [OUT_W-1:0] o_loss_value,
    output logic             o_saturated,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [P_W-1:0]   i_cfg_data
);

    logic [P_W-1:0] r_thresh;
    logic [BC_W-1:0] r_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_batch  <= BATCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESH: r_thresh <= i_cfg_data;
                CFG_BATCH:  r_batch  <= i_cfg_data[BC_W-1:0];
                default:    ;
            endcase
        end
    end

    logic w_push, w_pop, w_full, w_empty;
    t_qent w_push_data, w_q_data;

    jsd_front #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_p         (i_predicted_prob),
        .i_q         (i_target_prob),
        .i_last      (i_last_element),
        .i_threshold (r_thresh),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    jsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    jsd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (w_q_data),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .i_batch   (r_batch),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_loss    (o_loss_value),
        .o_sat     (o_saturated)
    );

endmodule

>>> dv/jsd_loss_accumulate_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for jsd_loss_accumulate_core: directed, random and backpressure tests
// depends on jsd_pkg and the jsd_loss_accumulate_core rtl

module jsd_loss_accumulate_core_tb;
    import jsd_pkg::*;

    localparam int          COUNT_BITS     = 20;
    localparam int          LOG_TABLE_BITS = 10;
    localparam int          TAB_SIZE       = 1 << LOG_TABLE_BITS;
    localparam longint      LN2            = 744261118;
    localparam bit [63:0]   SUM_MAX        = (64'd1 << (32 + COUNT_BITS)) - 1;
    localparam bit [63:0]   LOSS_MAX       = (64'd1 << 52) - 1;
    localparam bit [63:0]   ONE_Q30        = 64'd1 << 30;
    localparam int          SETTLE_CYCLES  = 200;
    localparam int          HOLD_CYCLES    = 1500;
    localparam longint      CYCLE_LIMIT    = 2000000;

    typedef struct {
        bit [OUT_W-1:0] loss;
        bit             sat;
    } t_loss_exp;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [P_W-1:0]   i_predicted_prob = '0;
    logic [P_W-1:0]   i_target_prob = '0;
    logic             i_last_element = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [OUT_W-1:0] o_loss_value;
    logic             o_saturated;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_index = CFG_THRESH;
    logic [P_W-1:0]   i_cfg_data = '0;

    jsd_loss_accumulate_core #(
        .COUNT_BITS(COUNT_BITS),
        .LOG_TABLE_BITS(LOG_TABLE_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_predicted_prob(i_predicted_prob),
        .i_target_prob(i_target_prob),
        .i_last_element(i_last_element),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_loss_value(o_loss_value),
        .o_saturated(o_saturated),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mirrored block state
    longint    ln_tab [TAB_SIZE];
    bit [63:0] thresh_q30 = THRESH_RESET;
    bit [63:0] batch_div = BATCH_RESET;
    bit [63:0] loss_acc = '0;

    t_loss_exp loss_expected [$];
    int        n_items = 0;
    int        n_losses = 0;
    int        n_errors = 0;
    longint    cycle_cnt = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_cnt = 0;

    function automatic void build_ln_tab();
        bit [63:0] m;
        bit [63:0] r;
        for (int i = 0; i < TAB_SIZE; i++) begin
            m = ONE_Q30 + (64'(i) << (30 - LOG_TABLE_BITS));
            r = '0;
            for (int b = 29; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (ONE_Q30 << 1)) begin
                    m = m >> 1;
                    r[b] = 1'b1;
                end
            end
            ln_tab[i] = longint'((r * 64'(LN2)) >> 30);
        end
    endfunction

    function automatic longint ln_fixed(bit [63:0] x);
        int     e;
        int     idx;
        e = 0;
        if (x == 0) x = 1;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        if (e >= LOG_TABLE_BITS) idx = int'((x >> (e - LOG_TABLE_BITS)) & (TAB_SIZE - 1));
        else idx = int'((x << (LOG_TABLE_BITS - e)) & (TAB_SIZE - 1));
        return longint'(e - 30) * LN2 + ln_tab[idx];
    endfunction

    // floor(a * l / 2^30), wrapping like 64-bit unsigned math
    function automatic longint scaled_mul(bit [63:0] a, longint l);
        bit [63:0] mag;
        if (l >= 0) begin
            mag = (a * 64'(l)) >> 30;
            return longint'(mag);
        end
        mag = a * 64'(-l);
        mag = (mag + (ONE_Q30 - 1)) >> 30;
        return -longint'(mag);
    endfunction

    function automatic void predict_loss(bit [P_W-1:0] p, bit [P_W-1:0] q, bit last);
        bit [63:0] term;
        longint    t;
        bit [63:0] bc;
        t_loss_exp ex;
        if (64'(p) <= thresh_q30) begin
            term = (64'(q) * 64'(LN2)) >> 30;
        end else if (64'(q) <= thresh_q30) begin
            term = (64'(p) * 64'(LN2)) >> 30;
        end else begin
            t = scaled_mul(64'(p), ln_fixed(2 * 64'(p)))
              + scaled_mul(64'(q), ln_fixed(2 * 64'(q)))
              - scaled_mul(64'(p) + 64'(q), ln_fixed(64'(p) + 64'(q)));
            term = t > 0 ? 64'(t) : 64'd0;
        end
        loss_acc = loss_acc + term;
        if (loss_acc > SUM_MAX) loss_acc = SUM_MAX;
        if (last) begin
            bc = batch_div != 0 ? batch_div : 64'd1;
            ex.loss = OUT_W'(loss_acc / (2 * bc));
            ex.sat = 1'b0;
            if (loss_acc == SUM_MAX || loss_acc / (2 * bc) > LOSS_MAX) begin
                ex.loss = OUT_W'(LOSS_MAX);
                ex.sat = 1'b1;
            end
            loss_expected.push_back(ex);
            loss_acc = '0;
        end
    endfunction

    // receiver stall: one long hold on request, otherwise a shifting pattern
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
        end else begin
            case ((cycle_cnt >> 7) % 4)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 99) < 30);
                2: i_out_stall <= ($urandom_range(0, 99) < 75);
                default: i_out_stall <= ((cycle_cnt % 9) < 4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_loss_exp ex;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (loss_expected.size() == 0) begin
                $error("unexpected loss transaction: loss_value %0d", o_loss_value);
                n_errors++;
            end else begin
                ex = loss_expected.pop_front();
                n_losses++;
                if (o_loss_value !== ex.loss) begin
                    $error("loss_value: expected %0d, actual %0d", ex.loss, o_loss_value);
                    n_errors++;
                end
                if (o_saturated !== ex.sat) begin
                    $error("saturated: expected %0d, actual %0d", ex.sat, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_pair(bit [P_W-1:0] p, bit [P_W-1:0] q, bit last);
        i_in_valid <= 1'b1;
        i_predicted_prob <= p;
        i_target_prob <= q;
        i_last_element <= last;
        do @(posedge i_clk); while (o_in_stall);
        predict_loss(p, q, last);
        n_items++;
    endtask

    task automatic idle_sender(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (loss_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, bit [P_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESH) thresh_q30 = 64'(val);
        else batch_div = 64'(val[BC_W-1:0]);
    endtask

    function automatic bit [P_W-1:0] rand_prob();
        longint v;
        case ($urandom_range(0, 6))
            0: return '0;
            1, 2: return P_W'($urandom_range(0, 1 << 30));
            3: return P_W'($urandom);
            4: begin
                v = longint'(thresh_q30) + $urandom_range(0, 4) - 2;
                if (v < 0) v = 0;
                return P_W'(v);
            end
            5: return P_W'($urandom_range(0, 20000));
            default: return $urandom_range(0, 1) ? P_W'(1 << 30) : {P_W{1'b1}};
        endcase
    endfunction

    task automatic test_directed();
        send_pair('0, '0, 1'b1);
        send_pair(P_W'(1 << 30), '0, 1'b1);
        send_pair('0, P_W'(1 << 30), 1'b1);
        send_pair(P_W'(10737), P_W'(10737), 1'b1);
        send_pair(P_W'(10738), P_W'(10738), 1'b1);
        send_pair(P_W'(1 << 29), P_W'(1 << 29), 1'b0);
        send_pair(P_W'(1 << 29), P_W'(3 << 28), 1'b0);
        send_pair({P_W{1'b1}}, {P_W{1'b1}}, 1'b1);
        send_pair({P_W{1'b1}}, P_W'(1), 1'b1);
        send_pair(P_W'(123456789), P_W'(987654321), 1'b1);
        wait_drained();
        // zero batch count is treated as one
        write_cfg(CFG_BATCH, '0);
        write_cfg(CFG_THRESH, '0);
        send_pair(P_W'(1), P_W'(1), 1'b0);
        send_pair(P_W'(1), P_W'(1 << 30), 1'b0);
        send_pair(P_W'(1 << 30), P_W'(2), 1'b1);
        wait_drained();
        write_cfg(CFG_BATCH, P_W'(65535));
        write_cfg(CFG_THRESH, P_W'(1 << 30));
        send_pair(P_W'(1 << 30), P_W'(1 << 30), 1'b0);
        send_pair({P_W{1'b1}}, P_W'(5), 1'b1);
        send_pair(P_W'(1 << 30) + 1, {P_W{1'b1}}, 1'b1);
        wait_drained();
    endtask

    task automatic random_burst(int count, int last_pct);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
            end
            burst--;
            send_pair(rand_prob(), rand_prob(), $urandom_range(0, 99) < last_pct);
        end
        send_pair(rand_prob(), rand_prob(), 1'b1);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_cfg(CFG_THRESH, THRESH_RESET);
                    write_cfg(CFG_BATCH, P_W'(BATCH_RESET));
                end
                1: begin
                    write_cfg(CFG_THRESH, '0);
                    write_cfg(CFG_BATCH, P_W'(65535));
                end
                2: begin
                    write_cfg(CFG_THRESH, P_W'(1 << 30));
                    write_cfg(CFG_BATCH, P_W'($urandom_range(1, 8)));
                end
                default: begin
                    write_cfg(CFG_THRESH, P_W'($urandom_range(0, 1 << 20)));
                    write_cfg(CFG_BATCH, P_W'($urandom_range(0, 65535)));
                end
            endcase
            random_burst(315, 12);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        write_cfg(CFG_THRESH, THRESH_RESET);
        write_cfg(CFG_BATCH, P_W'(3));
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_pair(rand_prob(), rand_prob(), 1'b1);
        wait_drained();
    endtask

    initial begin
        build_ln_tab();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        $display("covered %0d element pairs and %0d loss transactions", n_items, n_losses);
        $display("thresholds 0 to 1.0, batch counts 0 to 65535, long output hold");
        if (n_errors == 0 && loss_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> jsd_loss_accumulate_core.f
src/jsd_pkg.sv
src/jsd_front.sv
src/jsd_fifo.sv
src/jsd_back.sv
src/jsd_loss_accumulate_core.sv
dv/jsd_loss_accumulate_core_tb.sv
